### rtl/mtws_pkg.sv
// ----------------------------------------------------------------------------
// mtws_pkg
// Shared types and constants for the multi-task watchdog supervisor: item
// and result beats, item kinds, slot state codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mtws_pkg;

    // Field widths fixed by the item and result formats
    localparam int KIND_W  = 2;
    localparam int TID_W   = 5;
    localparam int TST_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int TMO_W   = 16;

    // Configuration port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam logic REG_DUMP_ENABLE = 1'b0;   // word index of dump_enable

    // Slot state codes
    localparam logic [TST_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [TST_W-1:0] ST_ALIVE   = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        K_REGISTER = 2'd0,
        K_FEED     = 2'd1,
        K_MONITOR  = 2'd2,
        K_TIMEOUT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TID_W-1:0]   task_id;
        logic [TST_W-1:0]   task_state;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  assigned_slot;
        logic               register_full;
        logic               feed_ignored;
        logic               reload_pulse;
        logic               dump_request;
        logic [TMO_W-1:0]   timeouts_seen;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CLEAR,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the incoming item
        logic exec;         // apply register, feed or timeout update
        logic idx_clr;      // restart the slot walk
        logic idx_inc;      // advance the slot walk
        logic clear_cur;    // turn the current alive slot back to unknown
        logic load_res;     // load the result register
        logic res_reload;   // reload flag for the result being loaded
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;        // kind of the held item
        logic  count_zero;  // no slot registered
        logic  walk_last;   // walk sits on the last registered slot
        logic  cur_unknown; // current slot is unknown
    } t_stat;

endpackage

### rtl/mtws_ctrl.sv
// ----------------------------------------------------------------------------
// mtws_ctrl
// Sequencer for the supervisor: takes one item at a time, runs the
// two-pass slot walk for monitor ticks and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module mtws_ctrl
    import mtws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_valid
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.kind == K_MONITOR && !i_stat.count_zero) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_stat.cur_unknown) begin
                    n_state = S_RESP;
                end else if (i_stat.walk_last) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (i_stat.walk_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
                o_cmd.idx_clr = i_start;
            end
            S_EXEC: begin
                if (i_stat.kind == K_MONITOR) begin
                    // empty table: nothing can be unknown
                    o_cmd.load_res   = i_stat.count_zero;
                    o_cmd.res_reload = 1'b1;
                end else begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.load_res = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.cur_unknown) begin
                    o_cmd.load_res = 1'b1;
                end else if (i_stat.walk_last) begin
                    o_cmd.idx_clr = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_cur = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.load_res   = 1'b1;
                    o_cmd.res_reload = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RESP: begin
                o_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/mtws_dp.sv
// ----------------------------------------------------------------------------
// mtws_dp
// Datapath for the supervisor: slot state file, registration count, walk
// index, saturating timeout counter and the result register.
// ----------------------------------------------------------------------------
module mtws_dp
    import mtws_pkg::*;
#(
    parameter int MAX_TASKS = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_dump_enable,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output t_result o_result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [TST_W-1:0] r_slot [MAX_TASKS];
    t_item            r_item;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [IW-1:0]    r_idx;
    logic [TMO_W-1:0] r_tmo;
    logic [TMO_W-1:0] n_tmo;
    t_result          r_res;
    t_result          n_res;

    logic             tbl_full;
    logic             tid_oor;
    logic [TST_W-1:0] cur_st;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [TST_W-1:0] wr_data;

    assign tbl_full = (r_count >= CW'(MAX_TASKS));
    assign tid_oor  = (r_item.task_id >= TID_W'(MAX_TASKS));
    assign cur_st   = r_slot[r_idx];

    // Report status to the controller
    assign o_stat.kind        = r_item.kind;
    assign o_stat.count_zero  = (r_count == '0);
    assign o_stat.walk_last   = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.cur_unknown = (cur_st == ST_UNKNOWN);

    // Latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Pick the slot write for this cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = ST_UNKNOWN;
        if (i_cmd.exec && r_item.kind == K_REGISTER && !tbl_full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
        end else if (i_cmd.exec && r_item.kind == K_FEED && !tid_oor) begin
            wr_en   = 1'b1;
            wr_addr = r_item.task_id[IW-1:0];
            wr_data = r_item.task_state;
        end else if (i_cmd.clear_cur && cur_st == ST_ALIVE) begin
            wr_en = 1'b1;
        end
    end

    // Write the slot file
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[wr_addr] <= wr_data;
        end
    end

    // Advance counters
    always_comb begin
        n_count = r_count;
        n_tmo   = r_tmo;
        if (i_cmd.exec && r_item.kind == K_REGISTER && !tbl_full) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.exec && r_item.kind == K_TIMEOUT && r_tmo != '1) begin
            n_tmo = r_tmo + TMO_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tmo   <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_tmo   <= n_tmo;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // Build the result beat
    always_comb begin
        n_res               = '0;
        n_res.timeouts_seen = n_tmo;
        n_res.reload_pulse  = i_cmd.res_reload;
        if (i_cmd.exec) begin
            case (r_item.kind)
                K_REGISTER: begin
                    if (tbl_full) begin
                        n_res.register_full = 1'b1;
                    end else begin
                        n_res.assigned_slot = SLOT_W'(r_count);
                    end
                end
                K_FEED: begin
                    n_res.feed_ignored = tid_oor;
                end
                K_TIMEOUT: begin
                    n_res.dump_request = i_dump_enable && (r_tmo == '0);
                end
                default: begin
                    n_res.reload_pulse = i_cmd.res_reload;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

### rtl/multi_task_watchdog_supervisor.sv
// ----------------------------------------------------------------------------
// multi_task_watchdog_supervisor
// Software watchdog supervisor for up to MAX_TASKS client slots.
//
// Items enter on i_item and are accepted at an edge where start is high and
// busy is low; one item is handled at a time. Each item gives exactly one
// result beat on o_result, marked by o_valid for a single cycle; the
// receiver cannot stall it.
// Register, feed and timeout items pass from the execute state to the
// response state. Monitor tick: the slot walk reads one slot per cycle,
// first a scan for unknown slots that stops at the first one it finds,
// then, only if it finds none, a pass that returns alive slots to
// unknown. The walk covers the N registered slots; an empty table skips it.
// dump_enable sits at byte address 0 of the APB port; write it only while
// the block is idle. Reset clears the slot count, the timeout count and the
// walk, sets dump_enable and leaves the block idle; slot states hold
// garbage until a registration or a feed writes them.
// ----------------------------------------------------------------------------
module multi_task_watchdog_supervisor
    import mtws_pkg::*;
#(
    parameter int MAX_TASKS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item channel
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    // result channel
    output logic              o_valid,
    output t_result           o_result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd  cmd;
    t_stat stat;
    logic  r_dump_enable;
    logic  cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DUMP_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_dump_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_DUMP_ENABLE) ? APB_DW'(r_dump_enable) : '0;

    mtws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    mtws_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_dump_enable (r_dump_enable),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (o_result)
    );

    // An accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result beat lasts one cycle and frees the block
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result beat longer than one cycle");

    // At most one event flag per result
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_result.register_full, o_result.feed_ignored,
                              o_result.reload_pulse, o_result.dump_request}))
        else $error("several event flags in one result");

    // A refused registration grants no slot
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.register_full) |-> (o_result.assigned_slot == '0))
        else $error("slot granted on a full table");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-task watchdog supervisor. A scripted
// opening covers the empty-table monitor, out-of-range feeds, the first
// timeout dump, exempt states and a full table. After it come randomized feed
// rounds with noise between dump_enable changes, and a closing back-to-back
// stretch with a short timeout burst. Every result beat is checked field by
// field against a pinned result or an in-bench model of slots and counters.
// ----------------------------------------------------------------------------
module tb_top;
    import mtws_pkg::*;

    localparam int TASKS      = 20;
    localparam int STALL_MAX  = 2000;   // cycles with no beat in either direction
    localparam int SETTLE     = 50;     // longest monitor walk plus margin
    localparam logic [APB_AW-1:0] DUMP_EN_ADDR = {REG_DUMP_ENABLE, 2'b00};

    typedef struct {
        t_item   item;
        int      reps;
        bit      pinned;
        t_result want;
    } t_script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_item             i_item = '0;
    logic              o_valid;
    t_result           o_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Mirror of the supervisor state
    logic [TST_W-1:0]  slot_tbl [TASKS];
    int                slots_used = 0;
    logic [TMO_W-1:0]  tmo_count = '0;
    logic              dump_en = 1'b1;

    t_result           pending_results [$];
    t_script_row       script [$];
    int                err_count = 0;
    int                items_sent = 0;
    int                gap_odds = 0;    // 0: no idle bursts, else 1 in gap_odds
    int                quiet_cycles = 0;

    multi_task_watchdog_supervisor #(
        .MAX_TASKS(TASKS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one item to the mirror and return the beat it should produce
    function automatic t_result supervise(t_item it);
        t_result r;
        bit      any_unknown;
        int      i;
        r = '0;
        case (it.kind)
            K_REGISTER: begin
                if (slots_used >= TASKS) begin
                    r.register_full = 1'b1;
                end else begin
                    slot_tbl[slots_used] = ST_UNKNOWN;
                    r.assigned_slot = SLOT_W'(slots_used);
                    slots_used++;
                end
            end
            K_FEED: begin
                if (it.task_id >= TASKS) r.feed_ignored = 1'b1;
                else slot_tbl[it.task_id] = it.task_state;
            end
            K_MONITOR: begin
                any_unknown = 1'b0;
                for (i = 0; i < slots_used; i++)
                    if (slot_tbl[i] == ST_UNKNOWN) any_unknown = 1'b1;
                if (!any_unknown) begin
                    for (i = 0; i < slots_used; i++)
                        if (slot_tbl[i] == ST_ALIVE) slot_tbl[i] = ST_UNKNOWN;
                    r.reload_pulse = 1'b1;
                end
            end
            default: begin
                if (dump_en && tmo_count == '0) r.dump_request = 1'b1;
                if (tmo_count != '1) tmo_count++;
            end
        endcase
        r.timeouts_seen = tmo_count;
        return r;
    endfunction

    function automatic t_item make_item(t_kind k, int id, int st);
        t_item it;
        it.kind       = k;
        it.task_id    = TID_W'(id);
        it.task_state = TST_W'(st);
        return it;
    endfunction

    function automatic t_script_row row(t_kind k, int id, int st, int reps, bit pinned,
                                        t_result want);
        t_script_row s;
        s.item   = make_item(k, id, st);
        s.reps   = reps;
        s.pinned = pinned;
        s.want   = want;
        return s;
    endfunction

    // Junk between feeds: stray kinds, out-of-range slots, random fields
    function automatic t_item noise_item();
        t_item it;
        it = make_item(t_kind'($urandom_range(0, 3)), $urandom_range(0, 31),
                       $urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0)
            it = make_item(K_FEED, $urandom_range(TASKS, 31), $urandom_range(0, 3));
        return it;
    endfunction

    // Send one item beat, queue its expected result, then maybe idle
    task automatic drive(t_item it, bit pinned = 1'b0, t_result want = '0);
        t_result nxt;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        nxt = supervise(it);
        pending_results.push_back(pinned ? want : nxt);
        items_sent++;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Hold off until every result is back and the block has settled
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DUMP_EN_ADDR) dump_en = data[0];
        // leave the bus idle before the next transfer
        @(posedge i_clk);
    endtask

    // One software period: feed the slots in random order, then tick
    task automatic feed_round();
        int    order [TASKS];
        int    j;
        int    k;
        int    tmp;
        int    pick;
        int    st;
        for (j = 0; j < TASKS; j++) order[j] = j;
        for (j = TASKS - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        gap_odds = (gap_odds == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 1000000 : 3);
        for (j = 0; j < TASKS; j++) begin
            pick = $urandom_range(0, 19);
            st = (pick < 12) ? ST_ALIVE : (pick < 18) ? $urandom_range(2, 3) : ST_UNKNOWN;
            // a missed feed leaves the slot as it was
            if ($urandom_range(0, 24) != 0) drive(make_item(K_FEED, order[j], st));
            if ($urandom_range(0, 9) == 0) drive(noise_item());
        end
        repeat ($urandom_range(1, 2))
            drive(make_item(K_MONITOR, $urandom_range(0, 31), $urandom_range(0, 3)));
    endtask

    task automatic field_check(string name, int want, int got);
        if (want != got) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Check each result beat and watch for a stalled block
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result beat: %p", o_result);
                end else begin
                    want = pending_results.pop_front();
                    field_check("assigned_slot", int'(want.assigned_slot),
                                int'(o_result.assigned_slot));
                    field_check("register_full", int'(want.register_full),
                                int'(o_result.register_full));
                    field_check("feed_ignored", int'(want.feed_ignored),
                                int'(o_result.feed_ignored));
                    field_check("reload_pulse", int'(want.reload_pulse),
                                int'(o_result.reload_pulse));
                    field_check("dump_request", int'(want.dump_request),
                                int'(o_result.dump_request));
                    field_check("timeouts_seen", int'(want.timeouts_seen),
                                int'(o_result.timeouts_seen));
                end
            end
            if ((start && !busy) || o_valid) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("timeout: no beat for %0d cycles", STALL_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        foreach (slot_tbl[i]) slot_tbl[i] = ST_UNKNOWN;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening script; pinned rows carry results readable at a glance
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0}));
        script.push_back(row(K_FEED, 31, 3, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0}));
        script.push_back(row(K_FEED, TASKS, 1, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0}));
        // feed to a slot not yet registered: stored, no visible effect
        script.push_back(row(K_FEED, TASKS - 1, 1, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
        // first timeout dumps under the reset value of dump_enable
        script.push_back(row(K_TIMEOUT, 31, 3, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1}));
        script.push_back(row(K_TIMEOUT, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_REGISTER, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_FEED, 0, ST_ALIVE, 1, 1'b0, '0));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b0, '0));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b0, '0));
        script.push_back(row(K_REGISTER, 31, 3, 1, 1'b0, '0));
        // exempt states never block a reload and are never cleared
        script.push_back(row(K_FEED, 1, 2, 1, 1'b0, '0));
        script.push_back(row(K_FEED, 0, 3, 1, 1'b0, '0));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b0, '0));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b0, '0));
        script.push_back(row(K_FEED, 0, ST_UNKNOWN, 1, 1'b0, '0));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b0, '0));
        script.push_back(row(K_FEED, 0, ST_ALIVE, 1, 1'b0, '0));
        // fill the table; the last grant overwrites the early feed to it
        script.push_back(row(K_REGISTER, 0, 0, TASKS - 3, 1'b0, '0));
        script.push_back(row(K_REGISTER, 0, 0, 1, 1'b1,
                             t_result'{5'd19, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_REGISTER, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_MONITOR, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}));
        script.push_back(row(K_TIMEOUT, 0, 0, 1, 1'b1,
                             t_result'{5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd3}));

        gap_odds = 3;
        foreach (script[r])
            repeat (script[r].reps) drive(script[r].item, script[r].pinned, script[r].want);

        // Random rounds between dump_enable changes, idle bursts on
        drain();
        cfg_write(DUMP_EN_ADDR, 32'd0);
        gap_odds = 3;
        while (items_sent < 560) feed_round();
        drain();
        cfg_write(DUMP_EN_ADDR, 32'd1);
        gap_odds = 3;
        while (items_sent < 1060) feed_round();
        drain();
        cfg_write(DUMP_EN_ADDR, 32'd0);
        cfg_write(DUMP_EN_ADDR, 32'hFFFF_FFFF);

        // Closing stretch back to back: rounds, then a short timeout burst
        gap_odds = 0;
        while (items_sent < 1510) feed_round();
        repeat (8) drive(make_item(K_TIMEOUT, $urandom_range(0, 31), $urandom_range(0, 3)));
        feed_round();

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
